FILE: design/apq_pkg.sv
// ----------------------------------------------------------------------------
// apq_pkg
// Shared types and codes for the array priority queue: request and result
// structs, opcode and status codes, controller state and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package apq_pkg;

	localparam int ELEM_W  = 32;
	localparam int PRIO_W  = 8;
	localparam int ENTRY_W = ELEM_W + PRIO_W;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_PEEK   = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]               opcode;
		logic signed [ELEM_W-1:0] element_in;
		logic [PRIO_W-1:0]        priority_in;
	} apq_req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [ELEM_W-1:0] element_out;
		logic [PRIO_W-1:0]        priority_out;
		logic [3:0]               count_out;
	} apq_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SHIFT,
		S_FIN
	} apq_state_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic scan;
		logic shift_init;
		logic shift;
		logic finish;
	} apq_cmd_t;

	typedef struct packed {
		logic is_peek;
		logic is_del;
		logic empty;
		logic sweep_done;
	} apq_sts_t;

endpackage

`default_nettype wire

FILE: design/apq_ram.sv
// ----------------------------------------------------------------------------
// apq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module apq_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: design/apq_ctrl.sv
// ----------------------------------------------------------------------------
// apq_ctrl
// Controller: sequences decode, priority scan, shift-down and result.
// ----------------------------------------------------------------------------
`default_nettype none

module apq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire apq_pkg::apq_sts_t sts,
	output apq_pkg::apq_cmd_t      cmd
);

	import apq_pkg::*;

	apq_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_nx = S_DECODE;
			end
			S_DECODE: begin
				if ((sts.is_peek || sts.is_del) && !sts.empty) state_nx = S_SCAN;
				else state_nx = S_FIN;
			end
			S_SCAN: begin
				if (sts.sweep_done) state_nx = sts.is_del ? S_SHIFT : S_FIN;
			end
			S_SHIFT: begin
				if (sts.sweep_done) state_nx = S_FIN;
			end
			S_FIN: begin
				state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_DECODE: cmd.decode = 1'b1;
			S_SCAN: begin
				cmd.scan       = 1'b1;
				cmd.shift_init = sts.sweep_done && sts.is_del;
			end
			S_SHIFT: cmd.shift  = 1'b1;
			S_FIN:   cmd.finish = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule

`default_nettype wire

FILE: design/apq_dp.sv
// ----------------------------------------------------------------------------
// apq_dp
// Datapath: entry RAM, count, sweep address, best-priority search and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module apq_dp #(
	parameter int QUEUE_DEPTH = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire apq_pkg::apq_req_t req,
	input  wire apq_pkg::apq_cmd_t cmd,
	output apq_pkg::apq_sts_t      sts,
	output logic                   done,
	output apq_pkg::apq_rsp_t      rsp
);

	import apq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     rd_idx_q;
	logic              vld_q;
	logic [AW-1:0]     cmp_idx_q;
	logic [PRIO_W-1:0] best_q;
	logic [AW-1:0]     pos_q;
	logic [ELEM_W-1:0] elem_best_q;
	logic [1:0]        op_q;
	logic [ELEM_W-1:0] elem_q;
	logic [PRIO_W-1:0] prio_q;
	logic              fail_q;
	logic              done_q;
	apq_rsp_t          rsp_q;

	logic               full;
	logic               empty;
	logic               is_ins;
	logic               is_peek;
	logic               is_del;
	logic               issue;
	logic               ins_wr;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [PRIO_W-1:0]  rd_prio;
	logic [CW-1:0]      cnt_after;

	assign full    = (count_q == CW'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign is_ins  = (op_q == OP_INSERT);
	assign is_peek = (op_q == OP_PEEK);
	assign is_del  = (op_q == OP_DELETE);
	assign issue   = (cmd.scan || cmd.shift) && (rd_idx_q < count_q);
	assign ins_wr  = cmd.decode && is_ins && !full;
	assign rd_prio = ram_rdata[PRIO_W-1:0];

	assign ram_we    = ins_wr || (cmd.shift && vld_q);
	assign ram_waddr = ins_wr ? count_q[AW-1:0] : cmp_idx_q - AW'(1);
	assign ram_wdata = ins_wr ? {elem_q, prio_q} : ram_rdata;

	assign cnt_after = (is_del && !fail_q) ? count_q - CW'(1) : count_q;

	apq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vld_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.load || cmd.shift_init) begin
				vld_q <= 1'b0;
			end else begin
				vld_q <= issue;
			end
			if (ins_wr) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.finish) begin
				count_q <= cnt_after;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_q <= rd_idx_q[AW-1:0];
		if (cmd.load) begin
			op_q        <= req.opcode;
			elem_q      <= req.element_in;
			prio_q      <= req.priority_in;
			rd_idx_q    <= '0;
			best_q      <= '0;
			pos_q       <= '0;
			elem_best_q <= '0;
		end else if (cmd.shift_init) begin
			rd_idx_q <= CW'(pos_q) + CW'(1);
		end else if (issue) begin
			rd_idx_q <= rd_idx_q + CW'(1);
		end
		if (cmd.decode) begin
			fail_q <= (is_ins && full) || ((is_peek || is_del) && empty);
		end
		if (cmd.scan && vld_q && (rd_prio >= best_q)) begin
			best_q      <= rd_prio;
			pos_q       <= cmp_idx_q;
			elem_best_q <= ram_rdata[ENTRY_W-1:PRIO_W];
		end
		if (cmd.finish) begin
			rsp_q.status       <= fail_q ? (is_ins ? ST_FULL : ST_EMPTY) : ST_OK;
			rsp_q.element_out  <= (is_del && !fail_q) ? elem_best_q : '0;
			rsp_q.priority_out <= ((is_peek || is_del) && !fail_q) ? best_q : '0;
			rsp_q.count_out    <= 4'(cnt_after);
		end
	end

	always_comb begin
		sts.is_peek    = is_peek;
		sts.is_del     = is_del;
		sts.empty      = empty;
		sts.sweep_done = (rd_idx_q == count_q) && !vld_q;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

FILE: design/array_priority_queue_top.sv
// ----------------------------------------------------------------------------
// array_priority_queue_top
// Fixed-depth unsorted priority queue of (element, priority) pairs.
//
//   channel   ports                 direction  handshake
//   request   req (opcode, element, in         start & !busy
//             priority)
//   result    rsp (status, element, out        done, one cycle, no stall
//             priority, count)
//
// Insert writes its entry in the decode step and does not sweep. Peek and
// delete are paced by the single read port of the entry RAM, which the
// priority scan and the shift-down both sweep one entry a cycle.
// Reset empties the queue at once; the entry RAM itself is not cleared.
// A new request can be accepted in the cycle that done is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module array_priority_queue_top #(
	parameter int QUEUE_DEPTH = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire apq_pkg::apq_req_t req,
	output logic                   done,
	output apq_pkg::apq_rsp_t      rsp
);

	import apq_pkg::*;

	apq_cmd_t cmd;
	apq_sts_t sts;

	apq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	apq_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.sts   (sts),
		.done  (done),
		.rsp   (rsp)
	);

endmodule

`default_nettype wire

FILE: design/apq_checker.sv
// ----------------------------------------------------------------------------
// apq_checker
// Port-level checks on the request/result timing and result contents.
// ----------------------------------------------------------------------------
`default_nettype none

module apq_checker #(
	parameter int QUEUE_DEPTH = 8
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire apq_pkg::apq_rsp_t rsp
);

	import apq_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted request");

	a_done_on_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_FULL |-> rsp.count_out == 4'(QUEUE_DEPTH)
			&& rsp.element_out == '0 && rsp.priority_out == '0)
		else $error("full result with wrong contents");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_EMPTY |-> rsp.count_out == '0
			&& rsp.element_out == '0 && rsp.priority_out == '0)
		else $error("empty result with wrong contents");

endmodule

bind array_priority_queue_top apq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_apq_checker (.*);

`default_nettype wire

FILE: test/array_priority_queue_top_test.sv
// ----------------------------------------------------------------------------
// array_priority_queue_top_test
// Self-checking testbench for the array priority queue. A directed table walks
// the queue from empty to full and back, covering full on insert, empty on
// peek and delete, ties on the highest priority, and the unused opcode. A long
// random phase follows, biased in turns toward filling, toward draining and
// neither. Each response is checked field by field against the row's result
// or an internal model, with random idle cycles on the request side.
// ----------------------------------------------------------------------------

module array_priority_queue_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	import apq_pkg::*;

	localparam int DEPTH      = 8;
	localparam int ITEMS      = 1500;
	localparam int LIMIT      = 200000;
	localparam int DRAIN_WAIT = 2 * DEPTH + 20;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		apq_req_t cmd;
		logic     typed;
		apq_rsp_t want;
	} stim_row_t;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	apq_req_t req;
	logic     done;
	apq_rsp_t rsp;

	apq_rsp_t pending_responses[$];
	apq_rsp_t oldest_response;

	logic signed [ELEM_W-1:0] held_elem [DEPTH];
	logic [PRIO_W-1:0]        held_prio [DEPTH];
	int held_count = 0;

	int errors = 0;
	int cycles = 0;
	int n_insert = 0, n_full = 0, n_peek = 0, n_delete = 0, n_empty = 0, n_unused = 0;
	logic idle_on = 1'b1;

	array_priority_queue_top #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic apq_rsp_t predict_queue_response(apq_req_t cmd);
		apq_rsp_t          r;
		logic [PRIO_W-1:0] best;
		int                pos;
		r = '0;
		case (cmd.opcode)
			OP_INSERT: begin
				n_insert++;
				if (held_count >= DEPTH) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					held_elem[held_count] = cmd.element_in;
					held_prio[held_count] = cmd.priority_in;
					held_count++;
				end
			end
			OP_PEEK, OP_DELETE: begin
				if (cmd.opcode == OP_PEEK) n_peek++;
				else n_delete++;
				if (held_count == 0) begin
					r.status = ST_EMPTY;
					n_empty++;
				end else begin
					best = '0;
					pos = 0;
					for (int i = 0; i < held_count; i++) begin
						if (held_prio[i] >= best) begin
							best = held_prio[i];
							pos = i;
						end
					end
					r.priority_out = best;
					if (cmd.opcode == OP_DELETE) begin
						r.element_out = held_elem[pos];
						for (int i = pos; i + 1 < held_count; i++) begin
							held_elem[i] = held_elem[i + 1];
							held_prio[i] = held_prio[i + 1];
						end
						held_count--;
					end
				end
			end
			default: n_unused++;
		endcase
		r.count_out = 4'(held_count);
		return r;
	endfunction

	task automatic issue(input apq_req_t cmd, input logic typed, input apq_rsp_t want);
		apq_rsp_t predicted;
		while (idle_on && $urandom_range(99) < 33) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= cmd;
		do @(posedge clk); while (busy);
		predicted = predict_queue_response(cmd);
		pending_responses.push_back(typed ? want : predicted);
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (done) begin
			if (pending_responses.size() == 0) begin
				$error("response with no request outstanding");
				errors++;
			end else begin
				oldest_response = pending_responses.pop_front();
				if (rsp.status !== oldest_response.status) begin
					$error("status: expected %0d, got %0d",
						oldest_response.status, rsp.status);
					errors++;
				end
				if (rsp.element_out !== oldest_response.element_out) begin
					$error("element_out: expected %0d, got %0d",
						oldest_response.element_out, rsp.element_out);
					errors++;
				end
				if (rsp.priority_out !== oldest_response.priority_out) begin
					$error("priority_out: expected %0d, got %0d",
						oldest_response.priority_out, rsp.priority_out);
					errors++;
				end
				if (rsp.count_out !== oldest_response.count_out) begin
					$error("count_out: expected %0d, got %0d",
						oldest_response.count_out, rsp.count_out);
					errors++;
				end
			end
		end
	end

	initial begin
		stim_row_t directed [24];
		apq_req_t  cmd;
		int        bias;
		int        roll;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		directed = '{
			'{'{OP_PEEK,   32'sd0,          8'd0},   1'b1, '{ST_EMPTY, 32'sd0, 8'd0, 4'd0}},
			'{'{OP_DELETE, 32'sd0,          8'd0},   1'b1, '{ST_EMPTY, 32'sd0, 8'd0, 4'd0}},
			'{'{OP_UNUSED, 32'sh7fffffff,   8'd255}, 1'b1, '{ST_OK,    32'sd0, 8'd0, 4'd0}},
			'{'{OP_INSERT, 32'sh7fffffff,   8'd0},   1'b1, '{ST_OK,    32'sd0, 8'd0, 4'd1}},
			'{'{OP_INSERT, 32'sh80000000,   8'd255}, 1'b1, '{ST_OK,    32'sd0, 8'd0, 4'd2}},
			'{'{OP_INSERT, -32'sd1,         8'd255}, 1'b1, '{ST_OK,    32'sd0, 8'd0, 4'd3}},
			'{'{OP_INSERT, 32'sd0,          8'd128}, 1'b1, '{ST_OK,    32'sd0, 8'd0, 4'd4}},
			'{'{OP_INSERT, 32'sd5,          8'd1},   1'b1, '{ST_OK,    32'sd0, 8'd0, 4'd5}},
			'{'{OP_INSERT, 32'sh55555555,   8'd255}, 1'b1, '{ST_OK,    32'sd0, 8'd0, 4'd6}},
			'{'{OP_INSERT, 32'shaaaaaaaa,   8'd85},  1'b1, '{ST_OK,    32'sd0, 8'd0, 4'd7}},
			'{'{OP_INSERT, 32'sd1,          8'd170}, 1'b1, '{ST_OK,    32'sd0, 8'd0, 4'd8}},
			'{'{OP_INSERT, 32'sd9,          8'd255}, 1'b1, '{ST_FULL,  32'sd0, 8'd0, 4'd8}},
			'{'{OP_PEEK,   32'sd0,          8'd0},   1'b1, '{ST_OK,    32'sd0, 8'd255, 4'd8}},
			'{'{OP_UNUSED, 32'sd0,          8'd0},   1'b1, '{ST_OK,    32'sd0, 8'd0, 4'd8}},
			'{'{OP_DELETE, 32'sd0,          8'd0},   1'b1,
				'{ST_OK, 32'sh55555555, 8'd255, 4'd7}},
			'{'{OP_DELETE, 32'sd0,          8'd0},   1'b1, '{ST_OK, -32'sd1, 8'd255, 4'd6}},
			'{'{OP_DELETE, 32'sd0,          8'd0},   1'b1,
				'{ST_OK, 32'sh80000000, 8'd255, 4'd5}},
			'{'{OP_PEEK,   32'sd0,          8'd0},   1'b0, '0},
			'{'{OP_DELETE, 32'sd0,          8'd0},   1'b0, '0},
			'{'{OP_DELETE, 32'sd0,          8'd0},   1'b0, '0},
			'{'{OP_DELETE, 32'sd0,          8'd0},   1'b0, '0},
			'{'{OP_DELETE, 32'sd0,          8'd0},   1'b0, '0},
			'{'{OP_DELETE, 32'sd0,          8'd0},   1'b1,
				'{ST_OK, 32'sh7fffffff, 8'd0, 4'd0}},
			'{'{OP_DELETE, 32'sd0,          8'd0},   1'b1, '{ST_EMPTY, 32'sd0, 8'd0, 4'd0}}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			issue(directed[i].cmd, directed[i].typed, directed[i].want);

		for (int i = 0; i < ITEMS; i++) begin
			idle_on = !(i >= 700 && i < 1000);
			bias = (i / 60) % 3;
			roll = $urandom_range(99);
			case (bias)
				0:       cmd.opcode = roll < 60 ? OP_INSERT : roll < 75 ? OP_PEEK :
						roll < 96 ? OP_DELETE : OP_UNUSED;
				1:       cmd.opcode = roll < 25 ? OP_INSERT : roll < 40 ? OP_PEEK :
						roll < 95 ? OP_DELETE : OP_UNUSED;
				default: cmd.opcode = roll < 40 ? OP_INSERT : roll < 58 ? OP_PEEK :
						roll < 95 ? OP_DELETE : OP_UNUSED;
			endcase
			cmd.element_in = $urandom;
			case ($urandom_range(3))
				0:       cmd.priority_in = 8'($urandom_range(255));
				1:       cmd.priority_in = 8'($urandom_range(3));
				2:       cmd.priority_in = 8'($urandom_range(255, 252));
				default: cmd.priority_in = $urandom_range(1) ? 8'd255 : 8'd0;
			endcase
			issue(cmd, 1'b0, '0);
		end
		start <= 1'b0;

		while (pending_responses.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d requests: %0d inserts (%0d refused as full), %0d peeks,",
			n_insert + n_peek + n_delete + n_unused, n_insert, n_full, n_peek);
		$display("%0d deletes, %0d peek/delete on an empty queue, %0d unused opcodes",
			n_delete, n_empty, n_unused);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
design/apq_pkg.sv
design/apq_ram.sv
design/apq_ctrl.sv
design/apq_dp.sv
design/array_priority_queue_top.sv
design/apq_checker.sv
test/array_priority_queue_top_test.sv
